### src/gnc_pkg.sv
// Shared constants and control types for the gradient norm clipper.
package gnc_pkg;

    // Fraction bits of the gradient and norm format (Q8.24 by default)
    localparam int FRAC_BITS = 24;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 2 * VALUE_W;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int SCALE_W = FRAC_BITS + 1;

    // Epsilon of 1e-6, rounded to the nearest LSB
    localparam longint EPS_LSB_L = ((longint'(1) << FRAC_BITS) + 500000) / 1000000;
    localparam logic [VALUE_W:0] EPS_LSB = (VALUE_W + 1)'(EPS_LSB_L);

    // 1.0 in the scale format and the reset value of the maximum norm
    localparam logic [SCALE_W-1:0] SCALE_ONE      = SCALE_W'(longint'(1) << FRAC_BITS);
    localparam logic [VALUE_W-1:0] MAX_NORM_RESET = VALUE_W'(longint'(1) << FRAC_BITS);
    localparam logic [PROD_W-1:0]  ROUND_HALF     = PROD_W'(longint'(1) << (FRAC_BITS - 1));

    // Iteration counts of the shared root / divide unit
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = FRAC_BITS;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    // Command codes carried in the input tuser
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_SCALE = 1'b1;

    // Request from the sequencer to the iterative unit
    typedef struct packed {
        logic start;
        logic is_div;
    } iter_ctl_t;

    // Status back from the iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

### src/gnc_iter_unit.sv
// Shared shift/subtract unit: bit-serial square root and restoring division.
module gnc_iter_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  gnc_pkg::iter_ctl_t          ctl,
    input  logic [gnc_pkg::SUM_W-1:0]   radicand,
    input  logic [gnc_pkg::VALUE_W-1:0] dividend,
    input  logic [gnc_pkg::VALUE_W:0]   divisor,
    output gnc_pkg::iter_stat_t         stat,
    output logic [gnc_pkg::VALUE_W-1:0] result
);

    localparam int REM_W = gnc_pkg::VALUE_W + 3;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         is_div_reg, is_div_next;
    logic [gnc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [gnc_pkg::SUM_W-1:0]    src_reg, src_next;
    logic [gnc_pkg::VALUE_W:0]    den_reg, den_next;
    logic [gnc_pkg::VALUE_W-1:0]  res_reg, res_next;

    logic [REM_W-1:0]             op_a;
    logic [REM_W-1:0]             op_b;
    logic [REM_W:0]               diff;
    logic                         ge;

    // One trial subtract per cycle: root takes two radicand bits, divide one zero bit
    always_comb
    begin
        if (is_div_reg)
        begin
            op_a = {rem_reg[REM_W-2:0], 1'b0};
            op_b = {2'b00, den_reg};
        end
        else
        begin
            op_a = {rem_reg[REM_W-3:0], src_reg[gnc_pkg::SUM_W-1 -: 2]};
            op_b = {1'b0, res_reg, 2'b01};
        end
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = ~diff[REM_W];
    end

    // Sequencing of the iterations
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        src_next    = src_reg;
        den_next    = den_reg;
        res_next    = res_reg;
        if (ctl.start)
        begin
            busy_next   = 1'b1;
            is_div_next = ctl.is_div;
            res_next    = '0;
            src_next    = radicand;
            den_next    = divisor;
            if (ctl.is_div)
            begin
                cnt_next = gnc_pkg::CNT_W'(gnc_pkg::DIV_STEPS - 1);
                rem_next = REM_W'(dividend);
            end
            else
            begin
                cnt_next = gnc_pkg::CNT_W'(gnc_pkg::ROOT_STEPS - 1);
                rem_next = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[REM_W-1:0] : op_a;
            res_next = {res_reg[gnc_pkg::VALUE_W-2:0], ge};
            src_next = {src_reg[gnc_pkg::SUM_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            is_div_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            is_div_reg <= is_div_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        src_reg <= src_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

### src/gradient_norm_clipper_unit.sv
// Top level of the global gradient norm clipper: sequencer, multiplier and stream ports.
//
// Channel   Dir  Word contents                                   Handshake
// s_axis    in   tdata: grad_value; tuser: cmd, set_start        tvalid/tready
// m_axis    out  tdata: scaled_value, norm_value; tuser: clip    tvalid/tready
// max_norm  in   max_norm_wr_data                                max_norm_wr_en
//
// Accumulate words take the multiply and accumulate steps, scale words with a known
// norm the multiply and round steps. The first scale word after an accumulate adds
// the square root and, when clipping applies, the scale division; both run on one shared
// shift/subtract unit. A full output register stalls a scale word in its last step.
// rst_n clears the sum, the held norm and scale state, and sets max_norm to 1.0.
module gradient_norm_clipper_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // [31:0] grad_value
    input  logic [1:0]  s_axis_tuser,     // [0] cmd, [1] set_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,     // [31:0] scaled_value, [63:32] norm_value
    output logic        m_axis_tuser,     // [0] was_clipped
    input  logic        max_norm_wr_en,
    input  logic [31:0] max_norm_wr_data
);

    localparam int VW = gnc_pkg::VALUE_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_ROOT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_RND  = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [VW-1:0]                     max_norm_reg;
    logic [gnc_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [gnc_pkg::SCALE_W-1:0]       scale_reg, scale_next;
    logic                              scale_ready_reg, scale_ready_next;
    logic                              clip_reg, clip_next;
    logic [VW-1:0]                     norm_reg, norm_next;
    logic                              cmd_reg, start_reg, neg_reg;
    logic [VW-1:0]                     raw_reg, mag_reg;
    logic [gnc_pkg::PROD_W-1:0]        prod_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [VW-1:0]                     out_scaled_reg, out_norm_reg;
    logic                              out_clip_reg;

    logic [VW-1:0]                     in_mag;
    logic [VW-1:0]                     mul_b;
    logic [gnc_pkg::PROD_W-1:0]        prod_next;
    logic [gnc_pkg::SUM_W:0]           sum_add;
    logic [gnc_pkg::PROD_W-1:0]        rounded;
    logic [VW-1:0]                     round_mag;
    logic [VW-1:0]                     scaled_val;
    logic                              accept;
    logic                              out_load;
    gnc_pkg::iter_ctl_t                iter_ctl;
    gnc_pkg::iter_stat_t               iter_stat;
    logic [VW-1:0]                     iter_res;

    // Shared root / divide unit
    gnc_iter_unit u_iter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (iter_ctl),
        .radicand (sum_reg),
        .dividend (max_norm_reg),
        .divisor  ({1'b0, iter_res} + gnc_pkg::EPS_LSB),
        .stat     (iter_stat),
        .result   (iter_res)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_mag        = s_axis_tdata[VW-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;

    // Shared multiplier: square on accumulate, scale on emit
    assign mul_b     = (cmd_reg == gnc_pkg::CMD_SCALE) ? VW'(scale_reg) : mag_reg;
    assign prod_next = gnc_pkg::PROD_W'(mag_reg) * gnc_pkg::PROD_W'(mul_b);

    // Saturating sum of squares
    assign sum_add = {1'b0, (start_reg ? {gnc_pkg::SUM_W{1'b0}} : sum_reg)} + {1'b0, prod_reg};

    // Round magnitude to nearest, ties away, then restore sign
    assign rounded    = prod_reg + gnc_pkg::ROUND_HALF;
    assign round_mag  = rounded[gnc_pkg::FRAC_BITS +: VW];
    assign scaled_val = clip_reg ? (neg_reg ? (~round_mag + 1'b1) : round_mag) : raw_reg;

    assign out_load = (state_reg == ST_RND) && (!out_valid_reg || m_axis_tready);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        scale_next       = scale_reg;
        scale_ready_next = scale_ready_reg;
        clip_next        = clip_reg;
        norm_next        = norm_reg;
        iter_ctl         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser[0] == gnc_pkg::CMD_SCALE && !scale_ready_reg)
                    begin
                        iter_ctl.start = 1'b1;
                        state_next     = ST_ROOT;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = (cmd_reg == gnc_pkg::CMD_SCALE) ? ST_RND : ST_ACC;
            end
            ST_ACC:
            begin
                sum_next         = sum_add[gnc_pkg::SUM_W] ? '1 : sum_add[gnc_pkg::SUM_W-1:0];
                scale_ready_next = 1'b0;
                state_next       = ST_IDLE;
            end
            ST_ROOT:
            begin
                if (iter_stat.done)
                begin
                    norm_next = iter_res;
                    if (iter_res > max_norm_reg)
                    begin
                        iter_ctl.start  = 1'b1;
                        iter_ctl.is_div = 1'b1;
                        state_next      = ST_DIV;
                    end
                    else
                    begin
                        scale_next       = gnc_pkg::SCALE_ONE;
                        clip_next        = 1'b0;
                        scale_ready_next = 1'b1;
                        state_next       = ST_MUL;
                    end
                end
            end
            ST_DIV:
            begin
                if (iter_stat.done)
                begin
                    scale_next       = iter_res[gnc_pkg::SCALE_W-1:0];
                    clip_next        = 1'b1;
                    scale_ready_next = 1'b1;
                    state_next       = ST_MUL;
                end
            end
            ST_RND:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_norm_reg    <= gnc_pkg::MAX_NORM_RESET;
            sum_reg         <= '0;
            scale_reg       <= gnc_pkg::SCALE_ONE;
            scale_ready_reg <= 1'b0;
            clip_reg        <= 1'b0;
            norm_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sum_reg         <= sum_next;
            scale_reg       <= scale_next;
            scale_ready_reg <= scale_ready_next;
            clip_reg        <= clip_next;
            norm_reg        <= norm_next;
            out_valid_reg   <= out_valid_next;
            if (max_norm_wr_en)
            begin
                max_norm_reg <= max_norm_wr_data;
            end
        end
    end

    // Input word, product and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_axis_tuser[0];
            start_reg <= s_axis_tuser[1];
            neg_reg   <= s_axis_tdata[VW-1];
            raw_reg   <= s_axis_tdata;
            mag_reg   <= in_mag;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (out_load)
        begin
            out_scaled_reg <= scaled_val;
            out_norm_reg   <= norm_reg;
            out_clip_reg   <= clip_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_norm_reg, out_scaled_reg};
    assign m_axis_tuser  = out_clip_reg;

    // The root/divide unit only runs while the sequencer waits on it
    a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        iter_stat.busy |-> !s_axis_tready)
        else $error("iterative unit busy while input is open");

    // Completion only arrives in a waiting state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        iter_stat.done |-> (state_reg == ST_ROOT || state_reg == ST_DIV))
        else $error("iterative unit done outside root or divide step");

    // An accumulate always invalidates the held scale
    a_acc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |=> !scale_ready_reg)
        else $error("scale still marked ready after accumulate");

    // A clipped word carries a nonzero norm
    a_clip_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:32] != '0))
        else $error("clipped word with zero norm");

endmodule
